// File: design/u2jesc_pkg.sv
package u2jesc_pkg;

  // Widths of the configuration registers and of the port fields
  localparam int ChunkSizeW = 16;
  localparam int MaxRowsW   = 21;
  localparam int CfgDataW   = 21;
  localparam int CfgIdxW    = 1;
  localparam int CodeW      = 21;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgChunkSize = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRows   = 1'd1;

  // Reset values of the configuration registers
  localparam logic [ChunkSizeW-1:0] ChunkSizeRst = 16'd30000;
  localparam logic [MaxRowsW-1:0]   MaxRowsRst   = 21'd1048576;

  // Result error codes
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrUtf8 = 2'd1;
  localparam logic [1:0] ErrRows = 2'd2;

  // Code point limits
  localparam logic [CodeW-1:0] CodeMax2   = 21'h00_0080;
  localparam logic [CodeW-1:0] CodeMax3   = 21'h00_0800;
  localparam logic [CodeW-1:0] CodeMax4   = 21'h01_0000;
  localparam logic [CodeW-1:0] CodeLimit  = 21'h10_ffff;
  localparam logic [CodeW-1:0] SurrLow    = 21'h00_d800;
  localparam logic [CodeW-1:0] SurrHigh   = 21'h00_dfff;
  localparam logic [CodeW-1:0] BmpLimit   = 21'h00_ffff;
  localparam logic [5:0]       HiSurrTag  = 6'b110110;
  localparam logic [5:0]       LoSurrTag  = 6'b110111;

  // Escape characters
  localparam logic [6:0] CharBackslash = 7'h5c;
  localparam logic [6:0] CharU         = 7'h75;
  localparam logic [2:0] LastSub       = 3'd5;

  typedef enum logic [1:0] {
    RunEmpty,
    RunAscii,
    RunEsc,
    RunErr
  } run_kind_e;

  // Number of continuation bytes announced by a lead byte, 0 for an invalid lead
  function automatic logic [1:0] lead_count(input logic [7:0] b);
    logic [1:0] c;
    c = 2'd0;
    if (b >= 8'hc2 && b <= 8'hdf) c = 2'd1;
    else if (b >= 8'he0 && b <= 8'hef) c = 2'd2;
    else if (b >= 8'hf0 && b <= 8'hf4) c = 2'd3;
    return c;
  endfunction

  // Lowercase hex digit
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) ch = 7'h30 + {3'b000, nib};
    else ch = 7'h57 + {3'b000, nib};
    return ch;
  endfunction

endpackage

// File: design/utf8_to_json_ascii_escaper_top.sv
// UTF-8 to JSON ASCII escaper.
// Slave stream: one UTF-8 byte per transfer in s_axis_tdata, s_axis_tlast on
// the final byte of the text. Master stream: one ASCII character per transfer;
// tlast marks the last character of a chunk or of the text, tuser carries the
// flag for the last result of a byte and the error code.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 chunk size, 1 max rows) at a clock edge; write only while idle.
// A byte is decoded into the run register at its transfer; its results then
// pass from the run register through the output register to the master port.
// Throughput: one byte per cycle for lead or middle bytes of a sequence, and for
// ASCII text unless the receiver stalls; a byte that completes a sequence gives
// six characters, or twelve for a surrogate pair, sent one per cycle unless stalled.
// An error result ends the run; bytes up to the end of the text are then
// dropped at one per cycle.
// Reset clears the decoder, the chunk and row counters and the run and output valid
// flags, and loads the registers with chunk size 30000 and max rows 1048576.
// When the receiver stalls, the output register holds its character, the run
// register holds any run with characters left, and s_axis_tready falls while it does.
module utf8_to_json_ascii_escaper_top #(
  parameter int CHUNK_BITS = 16,
  parameter int ROW_BITS   = 21
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] in_byte
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [6:0] out_char, [7] zero
  output logic                               m_axis_tlast,
  output logic [2:0]                         m_axis_tuser,  // [0] run_last, [2:1] error_code
  input  logic                               cfg_we_i,
  input  logic [u2jesc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [u2jesc_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int PosCmpW = (CHUNK_BITS > u2jesc_pkg::ChunkSizeW ?
                            CHUNK_BITS : u2jesc_pkg::ChunkSizeW) + 1;
  localparam int RowCmpW = (ROW_BITS > u2jesc_pkg::MaxRowsW ?
                            ROW_BITS : u2jesc_pkg::MaxRowsW);

  // Configuration
  logic [u2jesc_pkg::ChunkSizeW-1:0] row_len_q;
  logic [u2jesc_pkg::MaxRowsW-1:0]   row_limit_q;

  // Decoder state
  logic [1:0]                     pend_q, pend_d;
  logic [1:0]                     seq_q, seq_d;
  logic [u2jesc_pkg::CodeW-1:0]   acc_q, acc_d;
  logic                           hold_q, hold_d;

  // Run register
  logic                           run_valid_q, run_valid_d;
  u2jesc_pkg::run_kind_e          run_kind_q, run_kind_d;
  logic                           run_eos_q, run_eos_d;
  logic                           run_pair_q, run_pair_d;
  logic                           run_unit_q, run_unit_d;
  logic [2:0]                     run_sub_q, run_sub_d;
  logic [6:0]                     run_char_q;
  logic [15:0]                    run_u0_q, run_u1_q;

  // Chunk and row counters
  logic [CHUNK_BITS-1:0]          pos_q, pos_d;
  logic [ROW_BITS-1:0]            rows_q, rows_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic [6:0]                     out_char_q;
  logic                           out_ce_q;
  logic                           out_last_q;
  logic [1:0]                     out_err_q;

  // Decode signals
  logic                           accept;
  logic                           eos;
  logic [7:0]                     in_byte;
  logic [1:0]                     lead_cnt;
  logic [u2jesc_pkg::CodeW-1:0]   acc_shift;
  logic [u2jesc_pkg::CodeW-1:0]   surr_off;
  logic [u2jesc_pkg::CodeW-1:0]   min_code;
  logic                           bad;
  u2jesc_pkg::run_kind_e          dec_kind;
  logic                           dec_pair;
  logic [15:0]                    dec_u0, dec_u1;
  logic                           hold_eff;

  // Emitter signals
  logic                           out_free;
  logic                           emit;
  logic                           done;
  logic [6:0]                     e_char;
  logic                           e_ce;
  logic [1:0]                     e_err;
  logic                           set_hold;
  logic [15:0]                    cur_unit;
  logic [6:0]                     cur_char;
  logic                           is_last;
  logic                           row_full;
  logic [u2jesc_pkg::ChunkSizeW-1:0] cs_eff;
  logic                           ce;

  assign in_byte = s_axis_tdata;
  assign eos     = s_axis_tlast;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= u2jesc_pkg::ChunkSizeRst;
      row_limit_q <= u2jesc_pkg::MaxRowsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        u2jesc_pkg::CfgChunkSize: row_len_q   <= cfg_data_i[u2jesc_pkg::ChunkSizeW-1:0];
        u2jesc_pkg::CfgMaxRows:   row_limit_q <= cfg_data_i[u2jesc_pkg::MaxRowsW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign hold_eff  = hold_q || set_hold;
  assign lead_cnt  = u2jesc_pkg::lead_count(in_byte);
  assign acc_shift = {acc_q[u2jesc_pkg::CodeW-7:0], in_byte[5:0]};
  assign surr_off  = acc_shift - u2jesc_pkg::CodeMax4;

  always_comb begin
    unique case (seq_q)
      2'd1:    min_code = u2jesc_pkg::CodeMax2;
      2'd2:    min_code = u2jesc_pkg::CodeMax3;
      2'd3:    min_code = u2jesc_pkg::CodeMax4;
      default: min_code = '0;
    endcase
  end

  always_comb begin
    pend_d   = pend_q;
    seq_d    = seq_q;
    acc_d    = acc_q;
    bad      = 1'b0;
    dec_kind = u2jesc_pkg::RunEmpty;
    dec_pair = 1'b0;
    dec_u0   = acc_shift[15:0];
    dec_u1   = {u2jesc_pkg::LoSurrTag, surr_off[9:0]};
    if (hold_eff) begin
      dec_kind = u2jesc_pkg::RunEmpty;
    end else if (pend_q == 2'd0) begin
      if (!in_byte[7]) begin
        dec_kind = u2jesc_pkg::RunAscii;
      end else if (lead_cnt == 2'd0) begin
        bad = 1'b1;
      end else begin
        pend_d = lead_cnt;
        seq_d  = lead_cnt;
        unique case (lead_cnt)
          2'd1:    acc_d = {16'd0, in_byte[4:0]};
          2'd2:    acc_d = {17'd0, in_byte[3:0]};
          default: acc_d = {18'd0, in_byte[2:0]};
        endcase
      end
    end else if (in_byte[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      acc_d  = acc_shift;
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        if (acc_shift < min_code || acc_shift > u2jesc_pkg::CodeLimit ||
            (acc_shift >= u2jesc_pkg::SurrLow && acc_shift <= u2jesc_pkg::SurrHigh)) begin
          bad = 1'b1;
        end else begin
          dec_kind = u2jesc_pkg::RunEsc;
          if (acc_shift > u2jesc_pkg::BmpLimit) begin
            dec_pair = 1'b1;
            dec_u0   = {u2jesc_pkg::HiSurrTag, surr_off[19:10]};
          end
        end
      end
    end
    // cut-off sequence
    if (!hold_eff && !bad && eos && pend_d != 2'd0) bad = 1'b1;
    if (bad) dec_kind = u2jesc_pkg::RunErr;
    if (eos) begin
      pend_d = '0;
      seq_d  = '0;
      acc_d  = '0;
    end
  end

  always_comb begin
    hold_d = hold_eff;
    if (accept) hold_d = eos ? 1'b0 : (hold_eff || bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seq_q  <= '0;
      acc_q  <= '0;
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      if (accept) begin
        pend_q <= pend_d;
        seq_q  <= seq_d;
        acc_q  <= acc_d;
      end
    end
  end

  // ---------------------------------------------------------------- emitter
  assign out_free = !out_valid_q || m_axis_tready;
  assign cur_unit = run_unit_q ? run_u1_q : run_u0_q;
  assign cs_eff   = (row_len_q == '0) ? u2jesc_pkg::ChunkSizeW'(1) : row_len_q;
  assign row_full = (pos_q == '0) && (RowCmpW'(rows_q) >= RowCmpW'(row_limit_q));

  always_comb begin
    unique case (run_sub_q)
      3'd0:    cur_char = u2jesc_pkg::CharBackslash;
      3'd1:    cur_char = u2jesc_pkg::CharU;
      3'd2:    cur_char = u2jesc_pkg::hex_digit(cur_unit[15:12]);
      3'd3:    cur_char = u2jesc_pkg::hex_digit(cur_unit[11:8]);
      3'd4:    cur_char = u2jesc_pkg::hex_digit(cur_unit[7:4]);
      default: cur_char = u2jesc_pkg::hex_digit(cur_unit[3:0]);
    endcase
  end

  assign is_last = (run_kind_q == u2jesc_pkg::RunAscii) ||
                   (run_sub_q == u2jesc_pkg::LastSub && run_unit_q == run_pair_q);
  assign ce = (PosCmpW'(pos_q) + PosCmpW'(1) >= PosCmpW'(cs_eff)) || (run_eos_q && is_last);

  always_comb begin
    emit     = 1'b0;
    done     = 1'b0;
    e_char   = '0;
    e_ce     = 1'b0;
    e_err    = u2jesc_pkg::ErrNone;
    set_hold = 1'b0;
    pos_d    = pos_q;
    rows_d   = rows_q;
    if (run_valid_q) begin
      unique case (run_kind_q)
        u2jesc_pkg::RunEmpty: begin
          done = 1'b1;
        end
        u2jesc_pkg::RunErr: begin
          if (out_free) begin
            emit  = 1'b1;
            done  = 1'b1;
            e_err = u2jesc_pkg::ErrUtf8;
          end
        end
        u2jesc_pkg::RunAscii, u2jesc_pkg::RunEsc: begin
          if (out_free) begin
            emit = 1'b1;
            if (row_full) begin
              // drop the rest of the run
              done     = 1'b1;
              e_err    = u2jesc_pkg::ErrRows;
              set_hold = !run_eos_q;
            end else begin
              done   = is_last;
              e_char = (run_kind_q == u2jesc_pkg::RunAscii) ? run_char_q : cur_char;
              e_ce   = ce;
              pos_d  = ce ? '0 : pos_q + CHUNK_BITS'(1);
              if (pos_q == '0) rows_d = rows_q + ROW_BITS'(1);
            end
          end
        end
      endcase
    end
    if (done && run_eos_q) begin
      pos_d  = '0;
      rows_d = '0;
    end
  end

  assign s_axis_tready = !run_valid_q || done;

  always_comb begin
    run_valid_d = run_valid_q;
    run_kind_d  = run_kind_q;
    run_eos_d   = run_eos_q;
    run_pair_d  = run_pair_q;
    run_unit_d  = run_unit_q;
    run_sub_d   = run_sub_q;
    if (accept) begin
      run_valid_d = 1'b1;
      run_kind_d  = dec_kind;
      run_eos_d   = eos;
      run_pair_d  = dec_pair;
      run_unit_d  = 1'b0;
      run_sub_d   = '0;
    end else if (done) begin
      run_valid_d = 1'b0;
    end else if (emit) begin
      // advance to the next character of the escape
      if (run_sub_q == u2jesc_pkg::LastSub) begin
        run_sub_d  = '0;
        run_unit_d = 1'b1;
      end else begin
        run_sub_d = run_sub_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_kind_q  <= u2jesc_pkg::RunEmpty;
      run_eos_q   <= 1'b0;
      run_pair_q  <= 1'b0;
      run_unit_q  <= 1'b0;
      run_sub_q   <= '0;
      pos_q       <= '0;
      rows_q      <= '0;
    end else begin
      run_valid_q <= run_valid_d;
      run_kind_q  <= run_kind_d;
      run_eos_q   <= run_eos_d;
      run_pair_q  <= run_pair_d;
      run_unit_q  <= run_unit_d;
      run_sub_q   <= run_sub_d;
      pos_q       <= pos_d;
      rows_q      <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_char_q <= in_byte[6:0];
      run_u0_q   <= dec_u0;
      run_u1_q   <= dec_u1;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= e_char;
      out_ce_q   <= e_ce;
      out_last_q <= done;
      out_err_q  <= e_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_ce_q;
  assign m_axis_tuser  = {out_err_q, out_last_q};

`ifndef SYNTH
  a_err_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q != u2jesc_pkg::ErrNone) |->
      (out_last_q && !out_ce_q && out_char_q == '0))
    else $error("error result must be a lone, zero, unmarked character");

  a_hold_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && e_err != u2jesc_pkg::ErrNone && !run_eos_q && !accept) |=> hold_q)
    else $error("error result without dropping the rest of the text");

  a_pend_le_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= seq_q)
    else $error("more continuations pending than the sequence holds");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (run_sub_q <= u2jesc_pkg::LastSub))
    else $error("escape character index out of range");
`endif

endmodule

// File: tb/testbench.sv
module testbench;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int          SettleCycles = 20;

  typedef struct packed {
    logic [6:0] ch;
    logic       chunk_end;
    logic       run_last;
    logic [1:0] err;
  } esc_result_t;

  // Predicts the escaped character stream and checks what the block sends
  class escape_scoreboard;
    logic [u2jesc_pkg::ChunkSizeW-1:0] row_len;
    logic [u2jesc_pkg::MaxRowsW-1:0]   row_limit;
    logic [1:0]                        conts_left;
    logic [1:0]                        seq_conts;
    logic [u2jesc_pkg::CodeW-1:0]      code;
    logic [u2jesc_pkg::ChunkSizeW-1:0] chunk_pos;
    logic [u2jesc_pkg::MaxRowsW-1:0]   rows;
    bit                                dropping;
    logic [6:0]                        text[12];
    int                                text_len;
    esc_result_t                       run_q[$];
    esc_result_t                       expected_q[$];
    string                             hex_digits = "0123456789abcdef";
    int                                mismatches;
    int                                checked;
    int                                utf8_errors;
    int                                row_errors;

    function new();
      row_len     = u2jesc_pkg::ChunkSizeRst;
      row_limit   = u2jesc_pkg::MaxRowsRst;
      mismatches  = 0;
      checked     = 0;
      utf8_errors = 0;
      row_errors  = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      conts_left = '0;
      seq_conts  = '0;
      code       = '0;
      chunk_pos  = '0;
      rows       = '0;
      dropping   = 1'b0;
    endfunction

    function void set_reg(logic [u2jesc_pkg::CfgIdxW-1:0] idx,
                          logic [u2jesc_pkg::CfgDataW-1:0] val);
      unique case (idx)
        u2jesc_pkg::CfgChunkSize: row_len   = val[u2jesc_pkg::ChunkSizeW-1:0];
        u2jesc_pkg::CfgMaxRows:   row_limit = val[u2jesc_pkg::MaxRowsW-1:0];
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_char(logic [6:0] c);
      text[text_len] = c;
      text_len++;
    endfunction

    function void push_escape(logic [15:0] unit);
      logic [7:0] d;
      push_char(u2jesc_pkg::CharBackslash);
      push_char(u2jesc_pkg::CharU);
      for (int k = 3; k >= 0; k--) begin
        d = hex_digits[unit[4*k +: 4]];
        push_char(d[6:0]);
      end
    endfunction

    function void push_result(logic [6:0] c, logic ce, logic [1:0] err);
      esc_result_t r;
      r.ch        = c;
      r.chunk_end = ce;
      r.run_last  = 1'b0;
      r.err       = err;
      run_q.insert(run_q.size(), r);
    endfunction

    // Work out every result that one accepted byte causes
    function void note_byte(logic [7:0] b, bit eos);
      bit                           bad;
      bit                           ce;
      logic [16:0]                  cs;
      logic [u2jesc_pkg::CodeW-1:0] floor_code;
      logic [u2jesc_pkg::CodeW-1:0] offs;
      esc_result_t                  r;
      bad = 1'b0;
      text_len = 0;
      run_q.delete();
      if (dropping) begin
        if (eos) clear_stream();
        return;
      end
      if (conts_left == 0) begin
        if (b < 8'h80) begin
          push_char(b[6:0]);
        end else if (b >= 8'hc2 && b <= 8'hdf) begin
          conts_left = 2'd1;
          code = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'he) begin
          conts_left = 2'd2;
          code = {17'd0, b[3:0]};
        end else if (b >= 8'hf0 && b <= 8'hf4) begin
          conts_left = 2'd3;
          code = {18'd0, b[2:0]};
        end else begin
          bad = 1'b1;
        end
        seq_conts = conts_left;
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        code = {code[14:0], b[5:0]};
        conts_left--;
        if (conts_left == 0) begin
          case (seq_conts)
            2'd1:    floor_code = u2jesc_pkg::CodeMax2;
            2'd2:    floor_code = u2jesc_pkg::CodeMax3;
            default: floor_code = u2jesc_pkg::CodeMax4;
          endcase
          if (code < floor_code || code > u2jesc_pkg::CodeLimit ||
              (code >= u2jesc_pkg::SurrLow && code <= u2jesc_pkg::SurrHigh)) begin
            bad = 1'b1;
          end else if (code <= u2jesc_pkg::BmpLimit) begin
            push_escape(code[15:0]);
          end else begin
            offs = code - u2jesc_pkg::CodeMax4;
            push_escape({u2jesc_pkg::HiSurrTag, offs[19:10]});
            push_escape({u2jesc_pkg::LoSurrTag, offs[9:0]});
          end
        end
      end
      // a sequence cut off by the end of the text
      if (!bad && eos && conts_left != 0) bad = 1'b1;

      if (bad) begin
        push_result('0, 1'b0, u2jesc_pkg::ErrUtf8);
        dropping = 1'b1;
      end else begin
        cs = (row_len == 0) ? 17'd1 : {1'b0, row_len};
        for (int i = 0; i < text_len; i++) begin
          if (chunk_pos == 0) begin
            if (rows >= row_limit) begin
              push_result('0, 1'b0, u2jesc_pkg::ErrRows);
              dropping = 1'b1;
              break;
            end
            rows++;
          end
          ce = ({1'b0, chunk_pos} + 17'd1 >= cs) || (eos && i == text_len - 1);
          chunk_pos = ce ? '0 : chunk_pos + 1'b1;
          push_result(text[i], ce, u2jesc_pkg::ErrNone);
        end
      end

      foreach (run_q[i]) begin
        r = run_q[i];
        r.run_last = (i == run_q.size() - 1);
        expected_q.insert(expected_q.size(), r);
      end
      if (eos) clear_stream();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] data, logic last, logic [2:0] user);
      esc_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("char %h last %b user %b with nothing pending", data, last, user));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.err == u2jesc_pkg::ErrUtf8) utf8_errors++;
      else if (want.err == u2jesc_pkg::ErrRows) row_errors++;
      if (data !== {1'b0, want.ch} || last !== want.chunk_end ||
          user !== {want.err, want.run_last})
        report($sformatf("result %0d: got char %h last %b user %b, want char %h last %b user %b",
                         checked, data, last, user, want.ch, want.chunk_end,
                         {want.err, want.run_last}));
    endtask
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [7:0]                      m_axis_tdata;
  logic                            m_axis_tlast;
  logic [2:0]                      m_axis_tuser;
  logic                            cfg_we_i = 1'b0;
  logic [u2jesc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [u2jesc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  escape_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      cycle_count = 0;
  int               sent_bytes = 0;
  int               streams = 0;
  int               settings = 1;
  logic [7:0]       stream_q[$];

  utf8_to_json_ascii_escaper_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Result side: check each transfer, stall at random
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eos);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() + 1 : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, eos);
    sent_bytes++;
  endtask

  // Bytes of seq from the highest used one down; the last one ends the text
  task automatic send_seq(input logic [95:0] seq, input int n);
    for (int i = 0; i < n; i++) send_byte(seq[8*(n-1-i) +: 8], i == n - 1);
    streams++;
  endtask

  // Hold the input until every expected result has been received
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [u2jesc_pkg::ChunkSizeW-1:0] cs,
                            input logic [u2jesc_pkg::MaxRowsW-1:0] max_r);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= u2jesc_pkg::CfgChunkSize;
    cfg_data_i <= u2jesc_pkg::CfgDataW'(cs);
    @(posedge clk_i);
    cfg_idx_i  <= u2jesc_pkg::CfgMaxRows;
    cfg_data_i <= u2jesc_pkg::CfgDataW'(max_r);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(u2jesc_pkg::CfgChunkSize, u2jesc_pkg::CfgDataW'(cs));
    sb.set_reg(u2jesc_pkg::CfgMaxRows, u2jesc_pkg::CfgDataW'(max_r));
    settings++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic void encode(input logic [u2jesc_pkg::CodeW-1:0] cp, input int len);
    case (len)
      2: begin
        add_byte({3'b110, cp[10:6]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
      end
    endcase
    add_byte({2'b10, cp[5:0]});
  endfunction

  // One character's worth of bytes: mostly well formed, some noise and breakage
  function automatic void append_unit();
    int                           k;
    int                           len;
    logic [u2jesc_pkg::CodeW-1:0] cp;
    logic [7:0]                   b;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      add_byte(8'($urandom_range(0, 127)));
    end else if (k < 55) begin
      encode(u2jesc_pkg::CodeW'($urandom_range(32'h80, 32'h7ff)), 2);
    end else if (k < 68) begin
      cp = u2jesc_pkg::CodeW'($urandom_range(32'h800, 32'hffff));
      if (cp >= u2jesc_pkg::SurrLow && cp <= u2jesc_pkg::SurrHigh) cp[13] = 1'b1;
      encode(cp, 3);
    end else if (k < 80) begin
      encode(u2jesc_pkg::CodeW'($urandom_range(32'h10000, 32'h10ffff)), 4);
    end else if (k < 86) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (k < 92) begin
      case ($urandom_range(0, 2))
        0: begin  // overlong
          len = $urandom_range(2, 4);
          cp = u2jesc_pkg::CodeW'($urandom_range(0, len == 2 ? 32'h7f :
                                                    len == 3 ? 32'h7ff : 32'hffff));
          encode(cp, len);
        end
        1: encode(u2jesc_pkg::CodeW'($urandom_range(32'hd800, 32'hdfff)), 3);
        default: encode(u2jesc_pkg::CodeW'($urandom_range(32'h110000, 32'h13ffff)), 4);
      endcase
    end else if (k < 97) begin
      // wrong final continuation
      len = $urandom_range(2, 4);
      encode(u2jesc_pkg::CodeW'($urandom_range(32'h10000, 32'h10ffff)), len);
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      stream_q[stream_q.size() - 1] = b;
    end else begin
      // truncated sequence
      len = $urandom_range(2, 4);
      encode(u2jesc_pkg::CodeW'($urandom_range(32'h800, 32'hffff)), len);
      repeat ($urandom_range(1, len - 1)) void'(stream_q.pop_back());
    end
  endfunction

  task automatic send_random_stream();
    int units;
    units = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
    calm = ($urandom_range(0, 5) == 0);
    stream_q.delete();
    repeat (units) append_unit();
    foreach (stream_q[i]) begin
      if ($urandom_range(0, 79) == 0) wait_for_results();
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    streams++;
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) send_random_stream();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values; boundary code points, then each kind of bad input
    send_seq(96'h007fc280efbfbff48fbfbf, 11);
    send_seq(96'hff41, 2);       // bad lead, then a dropped byte
    send_seq(96'h80, 1);         // stray continuation
    send_seq(96'he080af, 3);     // overlong
    send_seq(96'heda080, 3);     // surrogate
    send_seq(96'hf4908080, 4);   // above the code space
    send_seq(96'hc341, 2);       // ASCII inside a sequence
    send_seq(96'he2, 1);         // cut off by end of text
    run_random(40);

    set_config(16'd7, 21'd3);
    run_random(70);
    set_config(16'd0, 21'd0);
    run_random(20);
    set_config(16'hffff, 21'h100000);
    run_random(60);
    set_config(16'd1, 21'd1);
    run_random(40);
    set_config(u2jesc_pkg::ChunkSizeW'($urandom_range(1, 24)),
               u2jesc_pkg::MaxRowsW'($urandom_range(1, 6)));
    run_random(70);
    settle();

    $display("sent %0d bytes in %0d texts across %0d register settings",
             sent_bytes, streams, settings);
    $display("checked %0d results, %0d invalid-sequence and %0d row-limit errors among them",
             sb.checked, sb.utf8_errors, sb.row_errors);
    if (sb.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
